@@ rtl/oipa_pkg.sv @@
// Shared types and constants for the ordered id pool allocator.
package oipa_pkg;

    // Pool geometry, fixed by the 3-bit id and 4-bit count fields
    localparam int POOL_SIZE = 8;
    localparam int ID_W      = 3;
    localparam int CNT_W     = 4;

    localparam logic [CNT_W-1:0] RESET_CAP = 4'd8;
    localparam logic [CNT_W-1:0] MAX_CAP   = 4'd8;
    localparam logic [CNT_W-1:0] MIN_CAP   = 4'd1;

    // Request codes
    typedef enum logic [1:0] {
        FUNC_BORROW_ANY = 2'd0,
        FUNC_BORROW_ID  = 2'd1,
        FUNC_RETURN     = 2'd2,
        FUNC_QUERY      = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NOT_FREE = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Operation applied to every cell of the free list chain
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_LOAD   = 3'd1,
        CELL_SHIFT  = 3'd2,
        CELL_REMOVE = 3'd3,
        CELL_APPEND = 3'd4
    } cell_op_t;

    // Control broadcast to all cells
    typedef struct packed {
        cell_op_t          op;
        logic [CNT_W-1:0]  load_cap;
        logic [ID_W-1:0]   new_id;
        logic              cmp_en;
        logic [ID_W-1:0]   cmp_id;
    } cell_ctrl_t;

endpackage

@@ rtl/oipa_cell.sv @@
// One slot of the ordered free list: holds an id, a valid flag and a match flag.
module oipa_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [oipa_pkg::ID_W-1:0]   idx,
    input  oipa_pkg::cell_ctrl_t        ctrl,
    input  logic [oipa_pkg::ID_W-1:0]   right_id,
    input  logic                        right_valid,
    input  logic                        left_valid,
    input  logic                        seen_in,
    output logic [oipa_pkg::ID_W-1:0]   id,
    output logic                        valid,
    output logic                        seen_out
);

    logic [oipa_pkg::ID_W-1:0] id_reg;
    logic [oipa_pkg::ID_W-1:0] id_next;
    logic                      valid_reg;
    logic                      valid_next;
    logic                      hit_reg;
    logic                      hit_next;

    // A hit here or anywhere to the left means this slot closes the gap
    assign seen_out = seen_in | hit_reg;
    assign id       = id_reg;
    assign valid    = valid_reg;

    // Next slot contents
    always_comb
    begin
        id_next    = id_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            oipa_pkg::CELL_LOAD:
            begin
                id_next    = idx;
                valid_next = ({1'b0, idx} < ctrl.load_cap);
            end
            oipa_pkg::CELL_SHIFT:
            begin
                id_next    = right_id;
                valid_next = right_valid;
            end
            oipa_pkg::CELL_REMOVE:
            begin
                if (seen_out)
                begin
                    id_next    = right_id;
                    valid_next = right_valid;
                end
            end
            oipa_pkg::CELL_APPEND:
            begin
                // first empty slot takes the returned id
                if (!valid_reg && left_valid)
                begin
                    id_next    = ctrl.new_id;
                    valid_next = 1'b1;
                end
            end
            default:
            begin
                id_next    = id_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Match against the id of the word being taken in
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.cmp_en)
        begin
            hit_next = valid_reg && (id_reg == ctrl.cmp_id);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg    <= idx;
            valid_reg <= ({1'b0, idx} < oipa_pkg::RESET_CAP);
            hit_reg   <= 1'b0;
        end
        else
        begin
            id_reg    <= id_next;
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

endmodule

@@ rtl/ordered_id_pool_allocator.sv @@
// Top level of the ordered id pool allocator: request sequencer, cell chain, result register.
//
// Each request word passes a compare step, as it is accepted, in which every
// cell of the free list compares its id against the requested id, and then an
// update step, in which the chain shifts, removes or appends in one step and the
// result word is registered. A request is taken whenever the sequencer is
// idle, even while the previous result still waits on m_axis; the update step
// then waits until the result register is free, so back-pressure on m_axis
// delays it. Writing cfg_wr_data refills the list with ids 0..capacity-1,
// clamping 0 to 1 and anything above 8 to 8; write only while no request is
// in flight.
module ordered_id_pool_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: pool capacity
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] func, [4:2] item_id, [7:5] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [2:0] granted_id, [4:3] status,
                                        // [5] any_borrowed, [9:6] free_count
);

    localparam int N     = oipa_pkg::POOL_SIZE;
    localparam int ID_W  = oipa_pkg::ID_W;
    localparam int CNT_W = oipa_pkg::CNT_W;

    oipa_pkg::state_t       state_reg;
    oipa_pkg::state_t       state_next;
    oipa_pkg::cell_ctrl_t   cell_ctrl;
    oipa_pkg::cell_op_t     exec_op;

    logic                   in_fire;
    logic                   out_free;
    logic                   exec_fire;

    oipa_pkg::func_t        func_reg;
    logic [ID_W-1:0]        req_id_reg;
    logic [CNT_W-1:0]       cap_reg;
    logic [CNT_W-1:0]       cap_next;
    logic [CNT_W-1:0]       len_reg;
    logic [CNT_W-1:0]       len_next;
    logic [N-1:0]           mask_reg;
    logic [N-1:0]           mask_next;

    logic                   out_valid_reg;
    logic [15:0]            out_data_reg;

    logic [ID_W-1:0]        granted;
    oipa_pkg::status_t      status;
    logic                   in_range;
    logic                   found;

    logic [ID_W-1:0]        cell_id    [N];
    logic                   cell_valid [N];
    logic                   cell_seen  [N];
    logic [N-1:0]           valid_vec;
    logic [N-1:0]           list_mask;

    // Handshake conditions
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oipa_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = oipa_pkg::ST_EXEC;
                end
            end
            oipa_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = oipa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = oipa_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        exec_fire     = 1'b0;
        unique case (state_reg)
            oipa_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            oipa_pkg::ST_EXEC:
            begin
                exec_fire = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Capacity clamp
    always_comb
    begin
        cap_next = cfg_wr_data;
        if (cfg_wr_data < oipa_pkg::MIN_CAP)
        begin
            cap_next = oipa_pkg::MIN_CAP;
        end
        else if (cfg_wr_data > oipa_pkg::MAX_CAP)
        begin
            cap_next = oipa_pkg::MAX_CAP;
        end
    end

    // Request decode and result
    assign in_range = ({1'b0, req_id_reg} < cap_reg);
    assign found    = cell_seen[N-1];

    always_comb
    begin
        granted   = '0;
        status    = oipa_pkg::STATUS_OK;
        exec_op   = oipa_pkg::CELL_HOLD;
        len_next  = len_reg;
        mask_next = mask_reg;
        case (func_reg)
            oipa_pkg::FUNC_BORROW_ANY:
            begin
                if (len_reg == '0)
                begin
                    status = oipa_pkg::STATUS_NOT_FREE;
                end
                else
                begin
                    granted   = cell_id[0];
                    exec_op   = oipa_pkg::CELL_SHIFT;
                    len_next  = len_reg - CNT_W'(1);
                    mask_next = mask_reg | (N'(1) << cell_id[0]);
                end
            end
            oipa_pkg::FUNC_BORROW_ID:
            begin
                if (!in_range)
                begin
                    status = oipa_pkg::STATUS_RANGE;
                end
                else if (!found)
                begin
                    status = oipa_pkg::STATUS_NOT_FREE;
                end
                else
                begin
                    granted   = req_id_reg;
                    exec_op   = oipa_pkg::CELL_REMOVE;
                    len_next  = len_reg - CNT_W'(1);
                    mask_next = mask_reg | (N'(1) << req_id_reg);
                end
            end
            oipa_pkg::FUNC_RETURN:
            begin
                if (!in_range)
                begin
                    status = oipa_pkg::STATUS_RANGE;
                end
                else
                begin
                    granted   = req_id_reg;
                    mask_next = mask_reg & ~(N'(1) << req_id_reg);
                    if (!found)
                    begin
                        exec_op  = oipa_pkg::CELL_APPEND;
                        len_next = len_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                granted = '0;
            end
        endcase
    end

    // Control broadcast to the chain
    always_comb
    begin
        cell_ctrl.op       = oipa_pkg::CELL_HOLD;
        cell_ctrl.load_cap = cap_next;
        cell_ctrl.new_id   = req_id_reg;
        cell_ctrl.cmp_en   = in_fire;
        cell_ctrl.cmp_id   = s_axis_tdata[4:2];
        if (cfg_wr_en)
        begin
            cell_ctrl.op = oipa_pkg::CELL_LOAD;
        end
        else if (exec_fire)
        begin
            cell_ctrl.op = exec_op;
        end
    end

    // Free list chain
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic [ID_W-1:0] r_id;
            logic            r_valid;
            logic            l_valid;
            logic            s_in;

            if (g == N - 1)
            begin : g_last
                assign r_id    = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid
                assign r_id    = cell_id[g+1];
                assign r_valid = cell_valid[g+1];
            end

            if (g == 0)
            begin : g_first
                assign l_valid = 1'b1;
                assign s_in    = 1'b0;
            end
            else
            begin : g_rest
                assign l_valid = cell_valid[g-1];
                assign s_in    = cell_seen[g-1];
            end

            oipa_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .idx         (ID_W'(g)),
                .ctrl        (cell_ctrl),
                .right_id    (r_id),
                .right_valid (r_valid),
                .left_valid  (l_valid),
                .seen_in     (s_in),
                .id          (cell_id[g]),
                .valid       (cell_valid[g]),
                .seen_out    (cell_seen[g])
            );

            assign valid_vec[g] = cell_valid[g];
        end
    endgenerate

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oipa_pkg::ST_IDLE;
            cap_reg       <= oipa_pkg::RESET_CAP;
            len_reg       <= oipa_pkg::RESET_CAP;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cap_reg  <= cap_next;
                len_reg  <= cap_next;
                mask_reg <= '0;
            end
            else if (exec_fire)
            begin
                len_reg  <= len_next;
                mask_reg <= mask_next;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg   <= oipa_pkg::func_t'(s_axis_tdata[1:0]);
            req_id_reg <= s_axis_tdata[4:2];
        end
        if (exec_fire)
        begin
            out_data_reg <= {6'd0, len_next, (mask_next != '0), status, granted};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Ids currently held in the free list
    always_comb
    begin
        list_mask = '0;
        for (int i = 0; i < N; i++)
        begin
            if (cell_valid[i])
            begin
                list_mask = list_mask | (N'(1) << cell_id[i]);
            end
        end
    end

    // Number of valid cells in the free list matches the free count
    a_len_matches_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == len_reg)
        else $error("free count disagrees with cell chain");

    // An id is never both free and borrowed
    a_free_borrowed_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (list_mask & mask_reg) == '0)
        else $error("id both in free list and borrowed");

    // Free count never exceeds capacity
    a_len_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= cap_reg)
        else $error("free count above capacity");

    // A stalled result holds the update cycle back
    a_exec_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == oipa_pkg::ST_EXEC && out_valid_reg && !m_axis_tready)
        |=> (state_reg == oipa_pkg::ST_EXEC))
        else $error("update ran while result register was full");

endmodule

@@ verif/ordered_id_pool_allocator_tb.sv @@
// Self-checking testbench for the ordered id pool allocator: request stream, scoreboard, tests.
module ordered_id_pool_allocator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_SIZE = oipa_pkg::POOL_SIZE;
    localparam int ID_W      = oipa_pkg::ID_W;
    localparam int CNT_W     = oipa_pkg::CNT_W;

    // Expected fields of one result word
    typedef struct packed {
        logic [ID_W-1:0]    granted_id;
        oipa_pkg::status_t  status;
        logic               any_borrowed;
        logic [CNT_W-1:0]   free_count;
    } pool_result_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_STEADY = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_MOSTLY = 2'd3
    } rx_mode_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [3:0]  cfg_wr_data   = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    // Shadow copy of the pool
    logic [CNT_W-1:0] shadow_cap;
    logic [ID_W-1:0]  shadow_free [POOL_SIZE];
    logic [CNT_W-1:0] shadow_free_len;
    logic [POOL_SIZE-1:0] shadow_borrowed;

    pool_result_t pending_results [$];

    int fail_count    = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int cap_writes    = 0;
    int status_seen [3] = '{0, 0, 0};
    int burst_left    = 0;
    int hold_req      = 0;

    ordered_id_pool_allocator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Set capacity (clamped) and refill the shadow list in order
    function automatic void shadow_refill(input logic [3:0] value);
        if (value < oipa_pkg::MIN_CAP)
            shadow_cap = oipa_pkg::MIN_CAP;
        else if (value > oipa_pkg::MAX_CAP)
            shadow_cap = oipa_pkg::MAX_CAP;
        else
            shadow_cap = value;
        for (int i = 0; i < POOL_SIZE; i++)
            shadow_free[i] = (i < shadow_cap) ? ID_W'(i) : '0;
        shadow_free_len = shadow_cap;
        shadow_borrowed = '0;
    endfunction

    // Slot of an id in the free list, -1 when absent
    function automatic int free_slot_of(input logic [ID_W-1:0] id);
        for (int i = 0; i < shadow_free_len; i++)
            if (shadow_free[i] == id)
                return i;
        return -1;
    endfunction

    // Close the gap left by a removed entry, keeping the order
    function automatic void free_drop(input int slot);
        for (int i = slot; i + 1 < shadow_free_len; i++)
            shadow_free[i] = shadow_free[i+1];
        shadow_free_len = shadow_free_len - 1'b1;
    endfunction

    // Apply one request to the shadow pool and return the expected word
    function automatic pool_result_t apply_request(input oipa_pkg::func_t func,
                                                   input logic [ID_W-1:0] id);
        pool_result_t res;
        int slot;
        res = '0;
        res.status = oipa_pkg::STATUS_OK;
        case (func)
            oipa_pkg::FUNC_BORROW_ANY:
            begin
                if (shadow_free_len == 0)
                    res.status = oipa_pkg::STATUS_NOT_FREE;
                else
                begin
                    res.granted_id = shadow_free[0];
                    free_drop(0);
                    shadow_borrowed[res.granted_id] = 1'b1;
                end
            end
            oipa_pkg::FUNC_BORROW_ID, oipa_pkg::FUNC_RETURN:
            begin
                slot = free_slot_of(id);
                if ({1'b0, id} >= shadow_cap)
                    res.status = oipa_pkg::STATUS_RANGE;
                else if (func == oipa_pkg::FUNC_BORROW_ID)
                begin
                    if (slot < 0)
                        res.status = oipa_pkg::STATUS_NOT_FREE;
                    else
                    begin
                        free_drop(slot);
                        shadow_borrowed[id] = 1'b1;
                        res.granted_id = id;
                    end
                end
                else
                begin
                    // a duplicate return leaves the list alone
                    shadow_borrowed[id] = 1'b0;
                    if (slot < 0 && shadow_free_len < POOL_SIZE)
                    begin
                        shadow_free[shadow_free_len] = id;
                        shadow_free_len = shadow_free_len + 1'b1;
                    end
                    res.granted_id = id;
                end
            end
            default:
                ;
        endcase
        res.any_borrowed = |shadow_borrowed;
        res.free_count   = shadow_free_len;
        status_seen[res.status]++;
        return res;
    endfunction

    // Offer one request word, in bursts with random gaps; predict on acceptance
    task automatic send_word(input oipa_pkg::func_t func, input logic [ID_W-1:0] id);
        int gap;
        logic ready_seen;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, id, func};
        // tready is stable at the falling edge; the handshake lands on the next rising one
        do
        begin
            @(negedge clk);
            ready_seen = s_axis_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        burst_left--;
        words_sent++;
        pending_results.insert(pending_results.size(), apply_request(func, id));
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_until_settled();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Capacity write, only with the pool idle
    task automatic write_capacity(input logic [3:0] value);
        wait_until_settled();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_refill(value);
        cap_writes++;
    endtask

    task automatic flag_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Result checker: compare every accepted result word with the oldest expectation
    initial
    begin
        pool_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                words_checked++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: result word with none expected, expected nothing, actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    flag_field("granted_id", want.granted_id, m_axis_tdata[2:0]);
                    flag_field("status", want.status, m_axis_tdata[4:3]);
                    flag_field("any_borrowed", want.any_borrowed, m_axis_tdata[5]);
                    flag_field("free_count", want.free_count, m_axis_tdata[9:6]);
                end
            end
        end
    end

    // Receiver: rotating stall patterns plus long hold-offs on request
    initial
    begin
        rx_mode_t rx_mode;
        int mode_left;
        int hold_left;
        rx_mode   = RX_STEADY;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            else
                mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STEADY: m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // Hand-picked sequence at full capacity: ordering, errors, ignored id bits
    task automatic test_directed_ops();
        send_word(oipa_pkg::FUNC_QUERY, 3'd7);
        send_word(oipa_pkg::FUNC_BORROW_ANY, 3'd5);
        send_word(oipa_pkg::FUNC_BORROW_ANY, 3'd2);
        send_word(oipa_pkg::FUNC_BORROW_ANY, 3'd7);
        send_word(oipa_pkg::FUNC_BORROW_ID, 3'd5);
        send_word(oipa_pkg::FUNC_BORROW_ID, 3'd5);
        send_word(oipa_pkg::FUNC_RETURN, 3'd1);
        send_word(oipa_pkg::FUNC_RETURN, 3'd1);
        send_word(oipa_pkg::FUNC_RETURN, 3'd4);
        send_word(oipa_pkg::FUNC_BORROW_ANY, 3'd0);
        send_word(oipa_pkg::FUNC_BORROW_ID, 3'd7);
        // empty the pool, then one more on empty
        repeat (4) send_word(oipa_pkg::FUNC_BORROW_ANY, 3'd0);
        send_word(oipa_pkg::FUNC_RETURN, 3'd0);
        send_word(oipa_pkg::FUNC_QUERY, 3'd0);
    endtask

    // Clamped capacity writes and out-of-range ids
    task automatic test_capacity_edges();
        write_capacity(4'd0);
        send_word(oipa_pkg::FUNC_BORROW_ID, 3'd1);
        send_word(oipa_pkg::FUNC_RETURN, 3'd7);
        send_word(oipa_pkg::FUNC_BORROW_ANY, 3'd3);
        send_word(oipa_pkg::FUNC_BORROW_ANY, 3'd0);
        send_word(oipa_pkg::FUNC_RETURN, 3'd0);
        write_capacity(4'd15);
        send_word(oipa_pkg::FUNC_BORROW_ID, 3'd7);
        send_word(oipa_pkg::FUNC_RETURN, 3'd7);
    endtask

    // Random mix, biased toward ids that are free or borrowed at the time
    task automatic test_random_mix(input logic [3:0] cap, input int count);
        int pick;
        oipa_pkg::func_t func;
        logic [ID_W-1:0] id;
        write_capacity(cap);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            id   = ID_W'($urandom_range(0, 7));
            if (pick < 30)
                func = oipa_pkg::FUNC_BORROW_ANY;
            else if (pick < 55)
            begin
                func = oipa_pkg::FUNC_BORROW_ID;
                if (shadow_free_len != 0 && $urandom_range(0, 9) < 7)
                    id = shadow_free[$urandom_range(0, shadow_free_len - 1)];
            end
            else if (pick < 88)
            begin
                func = oipa_pkg::FUNC_RETURN;
                if (shadow_borrowed != 0 && $urandom_range(0, 3) != 0)
                    do
                        id = ID_W'($urandom_range(0, 7));
                    while (!shadow_borrowed[id]);
            end
            else
                func = oipa_pkg::FUNC_QUERY;
            send_word(func, id);
        end
    endtask

    // Long receiver hold-off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        write_capacity(4'd8);
        hold_req = 300;
        for (int k = 0; k < 60; k++)
            send_word(k % 3 == 2 ? oipa_pkg::FUNC_RETURN : oipa_pkg::FUNC_BORROW_ANY,
                      ID_W'($urandom_range(0, 7)));
    endtask

    // Main sequence
    initial
    begin
        shadow_refill(oipa_pkg::RESET_CAP);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_capacity_edges();
        test_random_mix(4'd8, 150);
        test_random_mix(4'd3, 130);
        test_random_mix(4'd1, 100);
        test_backpressure();
        test_random_mix(4'd6, 150);
        test_random_mix(4'd15, 150);
        test_random_mix(4'd2, 100);
        test_random_mix(4'd0, 60);
        wait_until_settled();

        $display("Sent %0d request words over %0d capacity settings, checked %0d result words.",
                 words_sent, cap_writes, words_checked);
        $display("Outcomes: %0d ok, %0d empty or not free, %0d out of range.",
                 status_seen[oipa_pkg::STATUS_OK], status_seen[oipa_pkg::STATUS_NOT_FREE],
                 status_seen[oipa_pkg::STATUS_RANGE]);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #500000;
        $display("Run timed out with %0d results outstanding.", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
